@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the page window mapping cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted
`define PWMC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds during reset
`define PWMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PWMC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PWMC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/pwmc_pkg.sv @@
// Package for the page window mapping cache: defaults, codes and shared types.
`default_nettype none
package pwmc_pkg;

  // Default configuration
  localparam int ENTRIES_DEF    = 16;
  localparam int PAGE_SHIFT_DEF = 12;
  localparam int REF_BITS_DEF   = 16;

  // Request codes
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_HIT         = 3'd0,
    ST_FILLED      = 3'd1,
    ST_IMPORT_FAIL = 3'd2,
    ST_VICTIM_BUSY = 3'd3,
    ST_PUT_UNREF   = 3'd4
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_DECIDE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // take the item and register the tag compare
    logic lookup;   // encode the match and read the count memory
    logic decide;   // update the table and load the result register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy; // result register full and stalled
  } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/pwmc_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module pwmc_ram #(
  parameter int WIDTH = pwmc_pkg::REF_BITS_DEF,
  parameter int DEPTH = pwmc_pkg::ENTRIES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/pwmc_ctrl.sv @@
// Request sequencer for the page window mapping cache.
`default_nettype none
`include "assert_macros.svh"
module pwmc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire pwmc_pkg::dp_status_t dp_status,
  output pwmc_pkg::ctrl_cmd_t       cmd
);

  pwmc_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pwmc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pwmc_pkg::S_IDLE: begin
        if (in_valid) state_nxt = pwmc_pkg::S_LOOKUP;
      end
      pwmc_pkg::S_LOOKUP: begin
        state_nxt = pwmc_pkg::S_DECIDE;
      end
      pwmc_pkg::S_DECIDE: begin
        if (!dp_status.out_busy) state_nxt = pwmc_pkg::S_IDLE;
      end
      default: begin
        state_nxt = pwmc_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      pwmc_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      pwmc_pkg::S_LOOKUP: begin
        cmd.lookup = 1'b1;
      end
      pwmc_pkg::S_DECIDE: begin
        cmd.decide = !dp_status.out_busy;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // An accepted item always goes to lookup, then straight to the update
  `PWMC_ASSERT(a_accept_to_lookup, clk, rst_n,
    (in_valid && !in_stall) |=> (state_r == pwmc_pkg::S_LOOKUP), "accept did not start lookup")
  `PWMC_ASSERT(a_lookup_to_decide, clk, rst_n,
    cmd.lookup |=> (state_r == pwmc_pkg::S_DECIDE), "lookup not followed by update")
  `PWMC_ASSERT(a_one_cmd, clk, rst_n,
    $onehot0({cmd.capture, cmd.lookup, cmd.decide}), "more than one command at once")

endmodule
`default_nettype wire

@@ rtl/pwmc_dp.sv @@
// Datapath of the page window mapping cache: tag store, count memory, result register.
`default_nettype none
`include "assert_macros.svh"
module pwmc_dp #(
  parameter int ENTRIES    = pwmc_pkg::ENTRIES_DEF,
  parameter int PAGE_SHIFT = pwmc_pkg::PAGE_SHIFT_DEF,
  parameter int REF_BITS   = pwmc_pkg::REF_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pwmc_pkg::ctrl_cmd_t  cmd,
  output pwmc_pkg::dp_status_t      dp_status,
  input  wire logic                 in_command,
  input  wire logic [31:0]          in_owner_id,
  input  wire logic [63:0]          in_io_address,
  input  wire logic                 in_import_ok,
  input  wire logic [3:0]           in_slot_index,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                out_status,
  output logic [3:0]                out_slot,
  output logic [11:0]               out_page_offset
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int PAGE_W = 64 - PAGE_SHIFT;
  localparam logic [63:0]       OFF_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [REF_BITS-1:0] REF_MAX = '1;
  localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

  // Tag store and valid bits
  logic               entry_valid_r [ENTRIES];
  logic [31:0]        entry_owner_r [ENTRIES];
  logic [PAGE_W-1:0]  entry_page_r  [ENTRIES];
  logic [IDX_W-1:0]   victim_r, victim_nxt;

  // Captured item
  logic               cmd_r;
  logic [31:0]        owner_r;
  logic [PAGE_W-1:0]  page_r;
  logic [11:0]        off_r;
  logic               import_r;
  logic [3:0]         put_slot_r;
  logic               put_oor_r;
  logic [ENTRIES-1:0] match_r;

  // Lookup results
  logic [IDX_W-1:0]   addr_r;
  logic               hit_r;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  pwmc_pkg::status_t  out_status_r;
  logic [3:0]         out_slot_r;
  logic [11:0]        out_off_r;

  // Count memory port
  logic                ram_we;
  logic [REF_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [REF_BITS-1:0] ram_rdata;

  logic [PAGE_W-1:0]   in_page;
  logic [63:0]         in_off_wide;
  logic [31:0]         in_slot_wide;
  logic [ENTRIES-1:0]  match_nxt;
  logic [IDX_W-1:0]    hit_idx;
  logic [IDX_W-1:0]    put_idx;
  logic [31:0]         addr_wide;
  logic [REF_BITS-1:0] refs_cur;
  pwmc_pkg::status_t   status_nxt;
  logic                fill;

  // Split the address and compare the item against every valid slot
  assign in_page      = in_io_address[63:PAGE_SHIFT];
  assign in_off_wide  = in_io_address & OFF_MASK;
  assign in_slot_wide = {28'd0, in_slot_index};

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_nxt[i] = entry_valid_r[i] && (entry_owner_r[i] == in_owner_id) &&
                     (entry_page_r[i] == in_page);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r      <= in_command;
      owner_r    <= in_owner_id;
      page_r     <= in_page;
      off_r      <= in_off_wide[11:0];
      import_r   <= in_import_ok;
      put_slot_r <= in_slot_index;
      put_oor_r  <= (in_slot_wide >= 32'(ENTRIES));
      match_r    <= match_nxt;
    end
  end

  // Encode the match; at most one slot matches, so an OR of indices will do
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_r[i]) hit_idx = hit_idx | IDX_W'(i);
    end
  end

  assign put_idx = IDX_W'({28'd0, put_slot_r});

  always_comb begin
    if (cmd_r == pwmc_pkg::CMD_PUT) begin
      ram_raddr = put_idx;
    end else if (|match_r) begin
      ram_raddr = hit_idx;
    end else begin
      ram_raddr = victim_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      addr_r <= ram_raddr;
      hit_r  <= |match_r;
    end
  end

  // Count of the addressed slot; a slot never filled reads as zero
  assign refs_cur = entry_valid_r[addr_r] ? ram_rdata : '0;

  // Decide the outcome and the count update
  always_comb begin
    ram_we     = 1'b0;
    ram_wdata  = refs_cur;
    fill       = 1'b0;
    status_nxt = pwmc_pkg::ST_HIT;
    if (cmd_r == pwmc_pkg::CMD_PUT) begin
      if (put_oor_r || (refs_cur == '0)) begin
        status_nxt = pwmc_pkg::ST_PUT_UNREF;
      end else begin
        ram_we    = cmd.decide;
        ram_wdata = refs_cur - REF_ONE;
      end
    end else if (hit_r) begin
      // saturating increment
      ram_we    = cmd.decide && (refs_cur != REF_MAX);
      ram_wdata = refs_cur + REF_ONE;
    end else if (refs_cur != '0) begin
      status_nxt = pwmc_pkg::ST_VICTIM_BUSY;
    end else if (!import_r) begin
      status_nxt = pwmc_pkg::ST_IMPORT_FAIL;
    end else begin
      status_nxt = pwmc_pkg::ST_FILLED;
      fill       = cmd.decide;
      ram_we     = cmd.decide;
      ram_wdata  = REF_ONE;
    end
  end

  assign victim_nxt = (victim_r == '0) ? LAST_IDX : (victim_r - IDX_W'(1));

  // Refill of the victim slot and FIFO pointer step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      victim_r <= LAST_IDX;
      for (int i = 0; i < ENTRIES; i++) begin
        entry_valid_r[i] <= 1'b0;
      end
    end else if (fill) begin
      victim_r              <= victim_nxt;
      entry_valid_r[addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fill) begin
      entry_owner_r[addr_r] <= owner_r;
      entry_page_r[addr_r]  <= page_r;
    end
  end

  pwmc_ram #(
    .WIDTH (REF_BITS),
    .DEPTH (ENTRIES)
  ) u_refs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .re    (cmd.lookup),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result register
  assign addr_wide     = {{(32 - IDX_W){1'b0}}, addr_r};
  assign out_valid_nxt = cmd.decide || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      out_status_r <= status_nxt;
      out_slot_r   <= (cmd_r == pwmc_pkg::CMD_PUT) ? put_slot_r : addr_wide[3:0];
      out_off_r    <= (cmd_r == pwmc_pkg::CMD_PUT) ? 12'd0 : off_r;
    end
  end

  assign dp_status.out_busy = out_valid_r && out_stall;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_slot           = out_slot_r;
  assign out_page_offset    = out_off_r;

  // A slot is never filled twice with the same tag
  `PWMC_ASSERT(a_match_onehot, clk, rst_n,
    cmd.lookup |-> $onehot0(match_r), "several slots hold the same page")
  // The result register is never overwritten while a result waits
  `PWMC_ASSERT(a_no_overwrite, clk, rst_n,
    cmd.decide |-> !(out_valid_r && out_stall), "result register overwritten")
  // Every refill moves the victim pointer on
  `PWMC_ASSERT(a_fill_steps, clk, rst_n,
    fill |=> (victim_r != $past(victim_r)), "victim pointer did not step")

endmodule
`default_nettype wire

@@ rtl/page_window_map_cache_unit.sv @@
// An accepted item passes through the tag compare register, the registered read of
//   the count memory and the count update, which loads the result register; a new
//   item is taken only once the last one has left the update step.
// A stalled result holds the block in its update step until it is taken.
// Reset (synchronous, rst_n low): valid bits cleared, victim pointer at the last
//   slot; counts of slots never filled read as zero, so no clearing pass is run.
`default_nettype none
module page_window_map_cache_unit #(
  parameter int ENTRIES    = pwmc_pkg::ENTRIES_DEF,
  parameter int PAGE_SHIFT = pwmc_pkg::PAGE_SHIFT_DEF,
  parameter int REF_BITS   = pwmc_pkg::REF_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [31:0] in_owner_id,
  input  wire logic [63:0] in_io_address,
  input  wire logic        in_import_ok,
  input  wire logic [3:0]  in_slot_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [3:0]       out_slot,
  output logic [11:0]      out_page_offset
);

  pwmc_pkg::ctrl_cmd_t  cmd;
  pwmc_pkg::dp_status_t dp_status;

  // Sequencer
  pwmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  // Tag store, counts and result register
  pwmc_dp #(
    .ENTRIES    (ENTRIES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .REF_BITS   (REF_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .dp_status       (dp_status),
    .in_command      (in_command),
    .in_owner_id     (in_owner_id),
    .in_io_address   (in_io_address),
    .in_import_ok    (in_import_ok),
    .in_slot_index   (in_slot_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_page_offset (out_page_offset)
  );

endmodule
`default_nettype wire

@@ dv/page_window_map_cache_unit_tb.sv @@
// Self-checking testbench for the page window mapping cache unit.
`timescale 1ns / 100ps
module page_window_map_cache_unit_tb;

  localparam int ENTRIES    = pwmc_pkg::ENTRIES_DEF;
  localparam int PAGE_SHIFT = pwmc_pkg::PAGE_SHIFT_DEF;
  localparam int REF_BITS   = pwmc_pkg::REF_BITS_DEF;
  localparam int PAGE_W     = 64 - PAGE_SHIFT;

  localparam int N_DIRECTED     = 26;
  localparam int N_RANDOM       = 1850;
  localparam int SAT_GETS       = 24;
  localparam int SAT_PUTS       = 27;
  localparam int POOL           = 24;
  localparam int TAIL_CYCLES    = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic        cmd;
    logic [31:0] owner;
    logic [63:0] addr;
    logic        imp;
    logic [3:0]  sel;
  } map_req_t;

  typedef struct packed {
    pwmc_pkg::status_t st;
    logic [3:0]        slot;
    logic [11:0]       off;
  } map_result_t;

  typedef struct {
    map_req_t    rq;
    bit          typed;
    map_result_t res;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = pwmc_pkg::CMD_GET;
  logic [31:0] in_owner_id = '0;
  logic [63:0] in_io_address = '0;
  logic        in_import_ok = 1'b0;
  logic [3:0]  in_slot_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [3:0]  out_slot;
  logic [11:0] out_page_offset;

  // Predicted table contents
  logic                slot_valid [ENTRIES];
  logic [31:0]         slot_owner [ENTRIES];
  logic [PAGE_W-1:0]   slot_page  [ENTRIES];
  logic [REF_BITS-1:0] slot_refs  [ENTRIES];
  int                  next_victim;

  map_result_t expected_results[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          status_seen [8];
  bit          calm = 1'b0;

  page_window_map_cache_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_owner_id     (in_owner_id),
    .in_io_address   (in_io_address),
    .in_import_ok    (in_import_ok),
    .in_slot_index   (in_slot_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_page_offset (out_page_offset)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Mapping table behaviour: result of one request, table updated in place
  function automatic map_result_t window_map_step(input map_req_t rq);
    map_result_t       r;
    logic [PAGE_W-1:0] pg;
    int                hit_idx;
    int                v;
    pg      = rq.addr[63:PAGE_SHIFT];
    hit_idx = -1;
    r.off   = 12'(rq.addr & ((64'd1 << PAGE_SHIFT) - 64'd1));
    if (rq.cmd == pwmc_pkg::CMD_GET) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit_idx < 0 && slot_valid[i] && slot_owner[i] == rq.owner && slot_page[i] == pg)
          hit_idx = i;
      end
      if (hit_idx >= 0) begin
        // count sticks at its maximum
        if (slot_refs[hit_idx] != '1) slot_refs[hit_idx]++;
        r.st   = pwmc_pkg::ST_HIT;
        r.slot = 4'(hit_idx);
      end else begin
        v      = next_victim;
        r.slot = 4'(v);
        if (slot_refs[v] != 0) begin
          r.st = pwmc_pkg::ST_VICTIM_BUSY;
        end else if (!rq.imp) begin
          r.st = pwmc_pkg::ST_IMPORT_FAIL;
        end else begin
          slot_valid[v] = 1'b1;
          slot_owner[v] = rq.owner;
          slot_page[v]  = pg;
          slot_refs[v]  = 1;
          next_victim   = (v == 0) ? ENTRIES - 1 : v - 1;
          r.st          = pwmc_pkg::ST_FILLED;
        end
      end
    end else begin
      r.off  = '0;
      r.slot = rq.sel;
      if (int'(rq.sel) >= ENTRIES || slot_refs[rq.sel] == 0) begin
        r.st = pwmc_pkg::ST_PUT_UNREF;
      end else begin
        slot_refs[rq.sel]--;
        r.st = pwmc_pkg::ST_HIT;
      end
    end
    return r;
  endfunction

  // Present one item, wait for it to be taken, queue its expected result
  task automatic send_item(input map_req_t rq, input bit typed, input map_result_t typed_res);
    map_result_t model_res;
    int          gap;
    in_valid      <= 1'b1;
    in_command    <= rq.cmd;
    in_owner_id   <= rq.owner;
    in_io_address <= rq.addr;
    in_import_ok  <= rq.imp;
    in_slot_index <= rq.sel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_res = window_map_step(rq);
    expected_results.push_back(typed ? typed_res : model_res);
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side back-pressure
  initial begin : stall_gen
    int n;
    forever begin
      @(posedge clk);
      n = calm ? 0 : idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 8)) @(posedge clk);
    end
  end

  // Result checker
  always @(posedge clk) begin
    map_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (!$isunknown(out_status)) status_seen[out_status]++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result status %0d slot %0d offset 'h%03h",
                   $realtime, out_status, out_slot, out_page_offset);
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.st || out_slot !== want.slot ||
            out_page_offset !== want.off) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: expected status %0d slot %0d offset 'h%03h, got %0d %0d 'h%03h",
                     $realtime, want.st, want.slot, want.off,
                     out_status, out_slot, out_page_offset);
        end
      end
    end
  end

  // Watchdog on cycles in which nothing moves
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Directed items: reset state, extremes, every status, a full wrap of the victim
  directed_row_t directed_rows [N_DIRECTED] = '{
    // put on a slot never filled
    '{'{pwmc_pkg::CMD_PUT, 32'd0, 64'd0, 1'b0, 4'd0}, 1'b1,
      '{pwmc_pkg::ST_PUT_UNREF, 4'd0, 12'h000}},
    // first miss with failed import, then the same miss filled
    '{'{pwmc_pkg::CMD_GET, 32'd0, 64'd0, 1'b0, 4'd0}, 1'b1,
      '{pwmc_pkg::ST_IMPORT_FAIL, 4'd15, 12'h000}},
    '{'{pwmc_pkg::CMD_GET, 32'd0, 64'd0, 1'b1, 4'd0}, 1'b1,
      '{pwmc_pkg::ST_FILLED, 4'd15, 12'h000}},
    '{'{pwmc_pkg::CMD_GET, 32'd0, 64'hFFF, 1'b0, 4'd9}, 1'b1,
      '{pwmc_pkg::ST_HIT, 4'd15, 12'hFFF}},
    // owner 'hFFFF_FFFE and top page
    '{'{pwmc_pkg::CMD_GET, 32'hFFFF_FFFE, '1, 1'b1, 4'd0}, 1'b1,
      '{pwmc_pkg::ST_FILLED, 4'd14, 12'hFFF}},
    '{'{pwmc_pkg::CMD_GET, 32'hFFFF_FFFE, 64'hFFFF_FFFF_FFFF_F000, 1'b0, 4'd0}, 1'b1,
      '{pwmc_pkg::ST_HIT, 4'd14, 12'h000}},
    // same page, other owner: a separate mapping
    '{'{pwmc_pkg::CMD_GET, 32'd0, 64'hFFFF_FFFF_FFFF_F123, 1'b1, 4'd0}, 1'b1,
      '{pwmc_pkg::ST_FILLED, 4'd13, 12'h123}},
    '{'{pwmc_pkg::CMD_GET, 32'hFFFF_FFFE, 64'd0, 1'b1, 4'd0}, 1'b0,
      '{pwmc_pkg::ST_HIT, 4'd0, 12'd0}},
    '{'{pwmc_pkg::CMD_GET, 32'd0, 64'h8000_0000_0000_0000, 1'b1, 4'd0}, 1'b0,
      '{pwmc_pkg::ST_HIT, 4'd0, 12'd0}},
    '{'{pwmc_pkg::CMD_GET, 32'h8000_0000, 64'h1000, 1'b1, 4'd0}, 1'b0,
      '{pwmc_pkg::ST_HIT, 4'd0, 12'd0}},
    '{'{pwmc_pkg::CMD_GET, 32'd1, 64'h5555_5555_5555_5555, 1'b1, 4'd0}, 1'b0,
      '{pwmc_pkg::ST_HIT, 4'd0, 12'd0}},
    '{'{pwmc_pkg::CMD_GET, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 4'd0}, 1'b0,
      '{pwmc_pkg::ST_HIT, 4'd0, 12'd0}},
    '{'{pwmc_pkg::CMD_GET, 32'hAAAA_AAAA, 64'h1ABC, 1'b1, 4'd0}, 1'b0,
      '{pwmc_pkg::ST_HIT, 4'd0, 12'd0}},
    // release the only reference, then release once too often
    '{'{pwmc_pkg::CMD_PUT, 32'hFFFF_FFFF, '1, 1'b1, 4'd13}, 1'b1,
      '{pwmc_pkg::ST_HIT, 4'd13, 12'h000}},
    '{'{pwmc_pkg::CMD_PUT, 32'd0, 64'd0, 1'b0, 4'd13}, 1'b1,
      '{pwmc_pkg::ST_PUT_UNREF, 4'd13, 12'h000}},
    // remaining fills walk the victim down to slot 0
    '{'{pwmc_pkg::CMD_GET, 32'd2, 64'h2000, 1'b1, 4'd0}, 1'b0,
      '{pwmc_pkg::ST_HIT, 4'd0, 12'd0}},
    '{'{pwmc_pkg::CMD_GET, 32'd3, 64'h3_0000_0001, 1'b1, 4'd0}, 1'b0,
      '{pwmc_pkg::ST_HIT, 4'd0, 12'd0}},
    '{'{pwmc_pkg::CMD_GET, 32'd4, 64'h0123_4567_89AB_CDEF, 1'b1, 4'd0}, 1'b0,
      '{pwmc_pkg::ST_HIT, 4'd0, 12'd0}},
    '{'{pwmc_pkg::CMD_GET, 32'd5, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 4'd0}, 1'b0,
      '{pwmc_pkg::ST_HIT, 4'd0, 12'd0}},
    '{'{pwmc_pkg::CMD_GET, 32'd6, 64'h6000, 1'b1, 4'd0}, 1'b0,
      '{pwmc_pkg::ST_HIT, 4'd0, 12'd0}},
    '{'{pwmc_pkg::CMD_GET, 32'd7, 64'h7000, 1'b1, 4'd0}, 1'b0,
      '{pwmc_pkg::ST_HIT, 4'd0, 12'd0}},
    '{'{pwmc_pkg::CMD_GET, 32'd8, 64'h8000, 1'b1, 4'd0}, 1'b0,
      '{pwmc_pkg::ST_HIT, 4'd0, 12'd0}},
    // victim back at slot 15, which still holds two references
    '{'{pwmc_pkg::CMD_GET, 32'd9, 64'h9777, 1'b1, 4'd0}, 1'b1,
      '{pwmc_pkg::ST_VICTIM_BUSY, 4'd15, 12'h777}},
    '{'{pwmc_pkg::CMD_PUT, 32'd0, 64'd0, 1'b0, 4'd15}, 1'b1,
      '{pwmc_pkg::ST_HIT, 4'd15, 12'h000}},
    '{'{pwmc_pkg::CMD_PUT, 32'd0, 64'd0, 1'b0, 4'd15}, 1'b1,
      '{pwmc_pkg::ST_HIT, 4'd15, 12'h000}},
    // victim free again but the import fails
    '{'{pwmc_pkg::CMD_GET, 32'd10, 64'hABC, 1'b0, 4'd0}, 1'b1,
      '{pwmc_pkg::ST_IMPORT_FAIL, 4'd15, 12'hABC}}
  };

  initial begin : stimulus
    map_req_t          rq;
    map_result_t       no_result;
    logic [31:0]       owner_set [5];
    logic [31:0]       pool_owner [POOL];
    logic [PAGE_W-1:0] pool_page [POOL];
    int                busy_slots [ENTRIES];
    int                nbusy;
    int                k;

    no_result = '{pwmc_pkg::ST_HIT, 4'd0, 12'd0};
    foreach (status_seen[i]) status_seen[i] = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
      slot_owner[i] = '0;
      slot_page[i]  = '0;
      slot_refs[i]  = '0;
    end
    next_victim = ENTRIES - 1;

    // Working set for the random part: a few owners, more pages than slots
    owner_set = '{32'd0, 32'hFFFF_FFFE, 32'd1, $urandom_range(2, 32'h7FFF_FFFF),
                  $urandom_range(32'h8000_0000, 32'hFFFF_FFFD)};
    for (int i = 0; i < POOL; i++) begin
      pool_owner[i] = owner_set[i % 5];
      pool_page[i]  = PAGE_W'({$urandom, $urandom});
    end
    pool_page[0] = '0;
    pool_page[1] = '1;
    pool_page[2] = '1;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].res);

    // Stack references on one slot back to back, then release them all and once more
    calm = 1'b1;
    for (int i = 0; i < SAT_GETS; i++) begin
      rq = '{pwmc_pkg::CMD_GET, 32'hFFFF_FFFE, {{PAGE_W{1'b1}}, PAGE_SHIFT'($urandom)},
             1'b1, 4'd0};
      send_item(rq, 1'b0, no_result);
    end
    for (int i = 0; i < SAT_PUTS; i++) begin
      rq = '{pwmc_pkg::CMD_PUT, $urandom, {$urandom, $urandom}, 1'($urandom), 4'd14};
      send_item(rq, 1'b0, no_result);
    end
    calm = 1'b0;

    // Random part: mostly gets from the working set and puts on held slots
    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 63) == 0) calm = !calm;
      rq.cmd   = ($urandom_range(0, 99) < 55) ? pwmc_pkg::CMD_GET : pwmc_pkg::CMD_PUT;
      rq.owner = $urandom;
      if (rq.owner == 32'hFFFF_FFFF) rq.owner = 32'hFFFF_FFFE;
      rq.addr  = {$urandom, $urandom};
      rq.imp   = ($urandom_range(0, 99) < 85);
      rq.sel   = 4'($urandom_range(0, 15));
      if (rq.cmd == pwmc_pkg::CMD_GET && $urandom_range(0, 9) != 0) begin
        k = $urandom_range(0, POOL - 1);
        rq.owner = pool_owner[k];
        rq.addr[63:PAGE_SHIFT] = pool_page[k];
      end
      if (rq.cmd == pwmc_pkg::CMD_PUT && $urandom_range(0, 9) < 8) begin
        nbusy = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_refs[i] != 0) begin
            busy_slots[nbusy] = i;
            nbusy++;
          end
        end
        if (nbusy > 0) rq.sel = 4'(busy_slots[$urandom_range(0, nbusy - 1)]);
      end
      send_item(rq, 1'b0, no_result);
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    // Drain, then give any stray result time to show up
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d directed items, %0d items stacking and releasing one slot, %0d random",
             N_DIRECTED, SAT_GETS + SAT_PUTS, N_RANDOM);
    $display("Results: hit/done %0d, filled %0d, import failed %0d, victim busy %0d, put unref %0d",
             status_seen[pwmc_pkg::ST_HIT], status_seen[pwmc_pkg::ST_FILLED],
             status_seen[pwmc_pkg::ST_IMPORT_FAIL], status_seen[pwmc_pkg::ST_VICTIM_BUSY],
             status_seen[pwmc_pkg::ST_PUT_UNREF]);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
